// ===== hw/rtl/ucer_pkg.sv =====
// ----------------------------------------------------------------------------
// ucer_pkg: shared definitions for the control endpoint responder
// Event, request and action codes, descriptor ROM contents, the micro-op and
// branch-condition codes, and the structs between sequencer and datapath.
// ----------------------------------------------------------------------------
package ucer_pkg;

	localparam int PACKET_BYTES_DEF = 8;

	// Descriptor sizes
	localparam int DEVDES_SIZE      = 18;
	localparam int CONFIG_DESC_SIZE = 66;
	localparam int MOUSE_SIZE       = 52;
	localparam int KBD_SIZE         = 63;

	// Endpoint event codes
	localparam logic [2:0] EV_SETUP  = 3'd0;
	localparam logic [2:0] EV_EP0_IN = 3'd1;
	localparam logic [2:0] EV_EP2_OUT = 3'd3;

	// Standard request codes and the setup packet length
	localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
	localparam logic [7:0] REQ_GET_DESC    = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
	localparam logic [7:0] SETUP_BYTES     = 8'h08;

	// Descriptor types
	localparam logic [7:0] DTYPE_DEVICE = 8'h01;
	localparam logic [7:0] DTYPE_CONFIG = 8'h02;
	localparam logic [7:0] DTYPE_REPORT = 8'h22;

	// Descriptor selector codes
	localparam logic [2:0] DESC_NONE  = 3'd0;
	localparam logic [2:0] DESC_DEV   = 3'd1;
	localparam logic [2:0] DESC_CFG   = 3'd2;
	localparam logic [2:0] DESC_MOUSE = 3'd3;
	localparam logic [2:0] DESC_KBD   = 3'd4;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_BYTE  = 3'd1,
		ACT_ZLP   = 3'd2,
		ACT_STALL = 3'd3,
		ACT_ADDR  = 3'd4,
		ACT_LED   = 3'd5
	} action_t;

	// Micro-operations driving the datapath
	typedef enum logic [3:0] {
		OP_WAIT    = 4'd0,
		OP_NOP     = 4'd1,
		OP_SETPEND = 4'd2,
		OP_SELDESC = 4'd3,
		OP_CHUNK   = 4'd4,
		OP_EMITB   = 4'd5,
		OP_ZLP     = 4'd6,
		OP_STALL   = 4'd7,
		OP_SETADDR = 4'd8,
		OP_SETCFG  = 4'd9,
		OP_ADDR    = 4'd10,
		OP_LED     = 4'd11,
		OP_NONE    = 4'd12
	} op_t;

	// Branch conditions
	typedef enum logic [3:0] {
		C_ALWAYS  = 4'd0,
		C_ACC     = 4'd1,
		C_SETUP   = 4'd2,
		C_CNT8    = 4'd3,
		C_REQ_GD  = 4'd4,
		C_REQ_SA  = 4'd5,
		C_REQ_SC  = 4'd6,
		C_SEL_OK  = 4'd7,
		C_N_ZERO  = 4'd8,
		C_LAST_B  = 4'd9,
		C_EV_IN   = 4'd10,
		C_EV_EP2  = 4'd11,
		C_PEND_GD = 4'd12,
		C_PEND_SA = 4'd13
	} cond_t;

	typedef struct packed {
		op_t  op;
		logic hold;
	} ctrl_t;

	typedef struct packed {
		logic acc;
		logic setup;
		logic cnt8;
		logic req_gd;
		logic req_sa;
		logic req_sc;
		logic sel_ok;
		logic n_zero;
		logic last_b;
		logic ev_in;
		logic ev_ep2;
		logic pend_gd;
		logic pend_sa;
	} flags_t;

	localparam logic [7:0] DEV_ROM [DEVDES_SIZE] = '{
		8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h08, 8'h34, 8'h12,
		8'h78, 8'h56, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
	};

	localparam logic [7:0] MOUSE_ROM [MOUSE_SIZE] = '{
		8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
		8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h05, 8'h15, 8'h00, 8'h25, 8'h01,
		8'h95, 8'h05, 8'h75, 8'h01, 8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h03,
		8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
		8'h15, 8'h81, 8'h25, 8'h7F, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
		8'hC0, 8'hC0
	};

	localparam logic [7:0] KBD_ROM [KBD_SIZE] = '{
		8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0,
		8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08,
		8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h05,
		8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
		8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01, 8'h95, 8'h06, 8'h75, 8'h08,
		8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
		8'h81, 8'h00, 8'hC0
	};

	localparam logic [7:0] CFG_ROM [CONFIG_DESC_SIZE] = '{
		8'h09, 8'h02, 8'h42, 8'h00, 8'h02, 8'h01, 8'h00, 8'hE0, 8'hFA,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
		8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h03, 8'h04, 8'h00, 8'h06,
		8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h03, 8'h01, 8'h01, 8'h00,
		8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00,
		8'h07, 8'h05, 8'h82, 8'h03, 8'h08, 8'h00, 8'h06,
		8'h07, 8'h05, 8'h02, 8'h03, 8'h01, 8'h00, 8'h00
	};

	// Look up one byte of the selected descriptor; out of range reads zero
	function automatic logic [7:0] rom_byte(input logic [2:0] sel, input logic [6:0] pos);
		logic [7:0] b;
		b = 8'h00;
		priority if (sel == DESC_DEV && pos < 7'(DEVDES_SIZE)) begin
			b = DEV_ROM[pos[4:0]];
		end else if (sel == DESC_CFG && pos < 7'(CONFIG_DESC_SIZE)) begin
			b = CFG_ROM[pos];
		end else if (sel == DESC_MOUSE && pos < 7'(MOUSE_SIZE)) begin
			b = MOUSE_ROM[pos[5:0]];
		end else if (sel == DESC_KBD && pos < 7'(KBD_SIZE)) begin
			b = KBD_ROM[pos[5:0]];
		end else begin
			b = 8'h00;
		end
		return b;
	endfunction

endpackage

// ===== hw/rtl/ucer_sequencer.sv =====
// ----------------------------------------------------------------------------
// ucer_sequencer: microprogram store and step counter
// Holds the control program, issues one micro-op per step and takes a
// two-way branch on a selected condition flag once the step completes.
// ----------------------------------------------------------------------------
module ucer_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            hold,
	input  ucer_pkg::flags_t flags,
	output ucer_pkg::op_t   op
);

	typedef logic [4:0] step_t;

	typedef struct packed {
		ucer_pkg::op_t   op;
		ucer_pkg::cond_t cond;
		step_t           jt;
		step_t           jf;
	} uword_t;

	// Program entry points
	localparam step_t P_WAIT  = 5'd0;
	localparam step_t P_EV    = 5'd1;
	localparam step_t P_CNT   = 5'd2;
	localparam step_t P_PEND  = 5'd3;
	localparam step_t P_RSA   = 5'd4;
	localparam step_t P_RSC   = 5'd5;
	localparam step_t P_SEL   = 5'd6;
	localparam step_t P_CHUNK = 5'd7;
	localparam step_t P_BYTE  = 5'd8;
	localparam step_t P_ZLP   = 5'd9;
	localparam step_t P_STALL = 5'd10;
	localparam step_t P_SA    = 5'd11;
	localparam step_t P_SC    = 5'd12;
	localparam step_t P_OTHER = 5'd13;
	localparam step_t P_EP2   = 5'd14;
	localparam step_t P_IN    = 5'd15;
	localparam step_t P_INSA  = 5'd16;
	localparam step_t P_ADDR  = 5'd17;
	localparam step_t P_LED   = 5'd18;
	localparam step_t P_NONE  = 5'd19;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		w = '{ucer_pkg::OP_WAIT, ucer_pkg::C_ACC, P_EV, P_WAIT};
		unique case (pc)
			P_WAIT:  w = '{ucer_pkg::OP_WAIT,    ucer_pkg::C_ACC,     P_EV,    P_WAIT};
			P_EV:    w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_SETUP,   P_CNT,   P_OTHER};
			P_CNT:   w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_CNT8,    P_PEND,  P_STALL};
			P_PEND:  w = '{ucer_pkg::OP_SETPEND, ucer_pkg::C_REQ_GD,  P_SEL,   P_RSA};
			P_RSA:   w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_REQ_SA,  P_SA,    P_RSC};
			P_RSC:   w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_REQ_SC,  P_SC,    P_STALL};
			P_SEL:   w = '{ucer_pkg::OP_SELDESC, ucer_pkg::C_SEL_OK,  P_CHUNK, P_STALL};
			P_CHUNK: w = '{ucer_pkg::OP_CHUNK,   ucer_pkg::C_N_ZERO,  P_ZLP,   P_BYTE};
			P_BYTE:  w = '{ucer_pkg::OP_EMITB,   ucer_pkg::C_LAST_B,  P_WAIT,  P_BYTE};
			P_ZLP:   w = '{ucer_pkg::OP_ZLP,     ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_STALL: w = '{ucer_pkg::OP_STALL,   ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_SA:    w = '{ucer_pkg::OP_SETADDR, ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_SC:    w = '{ucer_pkg::OP_SETCFG,  ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_OTHER: w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_EV_IN,   P_IN,    P_EP2};
			P_EP2:   w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_EV_EP2,  P_LED,   P_NONE};
			P_IN:    w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_PEND_GD, P_CHUNK, P_INSA};
			P_INSA:  w = '{ucer_pkg::OP_NOP,     ucer_pkg::C_PEND_SA, P_ADDR,  P_NONE};
			P_ADDR:  w = '{ucer_pkg::OP_ADDR,    ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_LED:   w = '{ucer_pkg::OP_LED,     ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			P_NONE:  w = '{ucer_pkg::OP_NONE,    ucer_pkg::C_ALWAYS,  P_WAIT,  P_WAIT};
			default: w = '{ucer_pkg::OP_WAIT,    ucer_pkg::C_ACC,     P_EV,    P_WAIT};
		endcase
		return w;
	endfunction

	step_t  pc_q;
	uword_t uw;
	logic   taken;

	assign uw = ucode(pc_q);
	assign op = uw.op;

	// Select the branch condition
	always_comb begin
		unique case (uw.cond)
			ucer_pkg::C_ALWAYS:  taken = 1'b1;
			ucer_pkg::C_ACC:     taken = flags.acc;
			ucer_pkg::C_SETUP:   taken = flags.setup;
			ucer_pkg::C_CNT8:    taken = flags.cnt8;
			ucer_pkg::C_REQ_GD:  taken = flags.req_gd;
			ucer_pkg::C_REQ_SA:  taken = flags.req_sa;
			ucer_pkg::C_REQ_SC:  taken = flags.req_sc;
			ucer_pkg::C_SEL_OK:  taken = flags.sel_ok;
			ucer_pkg::C_N_ZERO:  taken = flags.n_zero;
			ucer_pkg::C_LAST_B:  taken = flags.last_b;
			ucer_pkg::C_EV_IN:   taken = flags.ev_in;
			ucer_pkg::C_EV_EP2:  taken = flags.ev_ep2;
			ucer_pkg::C_PEND_GD: taken = flags.pend_gd;
			ucer_pkg::C_PEND_SA: taken = flags.pend_sa;
			default:             taken = 1'b0;
		endcase
	end

	// Advance the step counter unless the datapath holds the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_WAIT;
		end else if (!hold) begin
			pc_q <= taken ? uw.jt : uw.jf;
		end
	end

endmodule

// ===== hw/rtl/usb_control_endpoint_responder.sv =====
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder: EP0 / EP2 event responder for a HID device
// Microcoded control over a small datapath: decodes setup requests, serves
// four ROM descriptors in packet-sized chunks, applies addresses and LEDs.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | req_type, setup_count, request_code,
//           |                      | value_low/high, index_low, length_low,
//           |                      | led_report
//  output   | out_valid / out_ready| action, data_byte, packet_length,
//           |                      | configured, last_result
//
// One event at a time: in_ready is high only in the wait step of the program.
// A descriptor chunk is decoded in the event, count, pending, select and chunk
// steps on setup, or in the event, other, IN and chunk steps on EP0 IN, then
// sent at one byte per cycle unless held by the output register. Results
// leave through one output register; the program holds its step while that
// register is full and not taken. Other events give a single result.
// Reset clears the step counter, endpoint and descriptor state; no clearing pass.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder #(
	parameter int PACKET_BYTES = ucer_pkg::PACKET_BYTES_DEF,
	localparam int PLEN_W = $clog2(PACKET_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [7:0]        setup_count,
	input  logic [7:0]        request_code,
	input  logic [7:0]        value_low,
	input  logic [7:0]        value_high,
	input  logic [7:0]        index_low,
	input  logic [7:0]        length_low,
	input  logic [7:0]        led_report,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        action,
	output logic [7:0]        data_byte,
	output logic [PLEN_W-1:0] packet_length,
	output logic              configured,
	output logic              last_result
);

	ucer_pkg::op_t    op;
	ucer_pkg::flags_t flags;
	ucer_pkg::ctrl_t  ctrl;

	// Latched event fields
	logic [2:0] ev_q;
	logic [7:0] cnt_in_q, req_q, vlo_q, vhi_q, ilo_q, llo_q, led_q;

	// Endpoint state
	logic [7:0]        pend_q;
	logic [2:0]        sel_q;
	logic [6:0]        len_q;
	logic [6:0]        sent_q;
	logic [7:0]        addr_q;
	logic              configured_q;
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] left_q;

	// Output register
	logic                out_valid_q;
	ucer_pkg::action_t   out_action_q;
	logic [7:0]          out_data_q;
	logic [PLEN_W-1:0]   out_plen_q;
	logic                out_cfg_q;
	logic                out_last_q;

	logic accept, is_emit, out_free, emit_fire;
	ucer_pkg::action_t emit_action;
	logic [7:0]        emit_data;
	logic [PLEN_W-1:0] emit_plen;
	logic              emit_last;
	logic              emit_cfg;
	logic [2:0]        sel_new;
	logic [6:0]        len_new;
	logic [6:0]        remain;
	logic [PLEN_W-1:0] chunk_n;

	ucer_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.hold   (ctrl.hold),
		.flags  (flags),
		.op     (op)
	);

	assign in_ready = (op == ucer_pkg::OP_WAIT);
	assign accept   = in_valid && in_ready;

	// Decide which steps produce a result and whether they can go now
	assign is_emit   = (op == ucer_pkg::OP_EMITB)   || (op == ucer_pkg::OP_ZLP)  ||
	                   (op == ucer_pkg::OP_STALL)   || (op == ucer_pkg::OP_SETADDR) ||
	                   (op == ucer_pkg::OP_SETCFG)  || (op == ucer_pkg::OP_ADDR) ||
	                   (op == ucer_pkg::OP_LED)     || (op == ucer_pkg::OP_NONE);
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = is_emit && out_free;
	assign ctrl.op   = op;
	assign ctrl.hold = is_emit && !out_free;

	// Descriptor selection from the latched setup fields
	always_comb begin
		sel_new = ucer_pkg::DESC_NONE;
		len_new = 7'd0;
		priority if (vhi_q == ucer_pkg::DTYPE_DEVICE) begin
			sel_new = ucer_pkg::DESC_DEV;
			len_new = 7'(ucer_pkg::DEVDES_SIZE);
		end else if (vhi_q == ucer_pkg::DTYPE_CONFIG) begin
			sel_new = ucer_pkg::DESC_CFG;
			len_new = (llo_q < 8'(ucer_pkg::CONFIG_DESC_SIZE)) ? llo_q[6:0]
			                                                    : 7'(ucer_pkg::CONFIG_DESC_SIZE);
		end else if (vhi_q == ucer_pkg::DTYPE_REPORT && ilo_q == 8'd0) begin
			sel_new = ucer_pkg::DESC_MOUSE;
			len_new = 7'(ucer_pkg::MOUSE_SIZE);
		end else if (vhi_q == ucer_pkg::DTYPE_REPORT && ilo_q == 8'd1) begin
			sel_new = ucer_pkg::DESC_KBD;
			len_new = 7'(ucer_pkg::KBD_SIZE);
		end else begin
			sel_new = ucer_pkg::DESC_NONE;
			len_new = 7'd0;
		end
	end

	// Size the next chunk: min(remaining, packet size)
	always_comb begin
		remain = (len_q > sent_q) ? (len_q - sent_q) : 7'd0;
		if ({1'b0, remain} > 8'(PACKET_BYTES)) begin
			chunk_n = PLEN_W'(PACKET_BYTES);
		end else begin
			chunk_n = PLEN_W'(remain);
		end
	end

	// Branch flags for the sequencer
	always_comb begin
		flags.acc     = accept;
		flags.setup   = (ev_q == ucer_pkg::EV_SETUP);
		flags.cnt8    = (cnt_in_q == ucer_pkg::SETUP_BYTES);
		flags.req_gd  = (req_q == ucer_pkg::REQ_GET_DESC);
		flags.req_sa  = (req_q == ucer_pkg::REQ_SET_ADDRESS);
		flags.req_sc  = (req_q == ucer_pkg::REQ_SET_CONFIG);
		flags.sel_ok  = (sel_new != ucer_pkg::DESC_NONE);
		flags.n_zero  = (chunk_n == '0);
		flags.last_b  = (left_q == PLEN_W'(1));
		flags.ev_in   = (ev_q == ucer_pkg::EV_EP0_IN);
		flags.ev_ep2  = (ev_q == ucer_pkg::EV_EP2_OUT);
		flags.pend_gd = (pend_q == ucer_pkg::REQ_GET_DESC) &&
		                (sel_q != ucer_pkg::DESC_NONE) && (sel_q <= ucer_pkg::DESC_KBD);
		flags.pend_sa = (pend_q == ucer_pkg::REQ_SET_ADDRESS);
	end

	// Build the result for the current emit step
	always_comb begin
		emit_action = ucer_pkg::ACT_NONE;
		emit_data   = 8'd0;
		emit_plen   = '0;
		emit_last   = 1'b1;
		emit_cfg    = configured_q;
		unique case (op)
			ucer_pkg::OP_EMITB: begin
				emit_action = ucer_pkg::ACT_BYTE;
				emit_data   = ucer_pkg::rom_byte(sel_q, sent_q);
				emit_plen   = plen_q;
				emit_last   = (left_q == PLEN_W'(1));
			end
			ucer_pkg::OP_ZLP, ucer_pkg::OP_SETADDR: begin
				emit_action = ucer_pkg::ACT_ZLP;
			end
			ucer_pkg::OP_SETCFG: begin
				emit_action = ucer_pkg::ACT_ZLP;
				emit_cfg    = 1'b1;
			end
			ucer_pkg::OP_STALL: begin
				emit_action = ucer_pkg::ACT_STALL;
			end
			ucer_pkg::OP_ADDR: begin
				emit_action = ucer_pkg::ACT_ADDR;
				emit_data   = addr_q;
			end
			ucer_pkg::OP_LED: begin
				emit_action = ucer_pkg::ACT_LED;
				emit_data   = {7'd0, led_q[0]};
			end
			default: begin
				emit_action = ucer_pkg::ACT_NONE;
			end
		endcase
	end

	// Capture the event fields on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q     <= req_type;
			cnt_in_q <= setup_count;
			req_q    <= request_code;
			vlo_q    <= value_low;
			vhi_q    <= value_high;
			ilo_q    <= index_low;
			llo_q    <= length_low;
			led_q    <= led_report;
		end
	end

	// Endpoint state updates, one micro-op per cycle unless an emit step is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 8'd0;
			sel_q        <= ucer_pkg::DESC_NONE;
			len_q        <= 7'd0;
			sent_q       <= 7'd0;
			addr_q       <= 8'd0;
			configured_q <= 1'b0;
			plen_q       <= '0;
			left_q       <= '0;
		end else begin
			unique case (op)
				ucer_pkg::OP_SETPEND: pend_q <= req_q;
				ucer_pkg::OP_SELDESC: begin
					sel_q  <= sel_new;
					len_q  <= len_new;
					sent_q <= 7'd0;
				end
				ucer_pkg::OP_CHUNK: begin
					plen_q <= chunk_n;
					left_q <= chunk_n;
				end
				ucer_pkg::OP_EMITB: begin
					if (emit_fire) begin
						sent_q <= sent_q + 7'd1;
						left_q <= left_q - PLEN_W'(1);
					end
				end
				ucer_pkg::OP_SETADDR: begin
					if (emit_fire) addr_q <= vlo_q;
				end
				ucer_pkg::OP_SETCFG: begin
					if (emit_fire) configured_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_action_q <= emit_action;
			out_data_q   <= emit_data;
			out_plen_q   <= emit_plen;
			out_cfg_q    <= emit_cfg;
			out_last_q   <= emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_action_q;
	assign data_byte     = out_data_q;
	assign packet_length = out_plen_q;
	assign configured    = out_cfg_q;
	assign last_result   = out_last_q;

	// A descriptor byte is only sent from inside the selected length
	a_byte_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && op == ucer_pkg::OP_EMITB) |-> (sent_q < len_q && left_q != '0))
		else $error("descriptor byte sent past its length");

	// After the last result of an event the program returns to the wait step
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && emit_last) |=> in_ready)
		else $error("sequencer did not return to wait after last result");

	// A result in flight is never dropped by a stalled emit step
	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.hold |-> (out_valid_q && !out_ready))
		else $error("emit held with output register free");

	// Chunk length never exceeds the packet size
	a_chunk_size: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q <= PLEN_W'(PACKET_BYTES)) && (left_q <= plen_q))
		else $error("chunk counter out of range");

endmodule
